// ===== src/gflt_pkg.sv =====
// Shared types and constants of the group-favouring lock table.
// Used by the front classifier, the back executor and the top level.
package gflt_pkg;

    localparam logic [1:0] ACT_CREATE  = 2'd0;
    localparam logic [1:0] ACT_ACQUIRE = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_DESTROY = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_QUEUED = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [6:0] PCT_LIMIT = 7'd100;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  lock_index;
        logic [15:0] caller_pid;
        logic [15:0] caller_gid;
        logic [6:0]  favor_percent;
        logic [6:0]  random_draw;
        logic        index_ok;
    } gflt_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  created_index;
        logic        wake_valid;
        logic [15:0] wake_pid;
    } gflt_res_t;

endpackage

// ===== src/gflt_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module gflt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/gflt_front.sv =====
// Front part: takes input transactions, checks the slot index and queues
// them as commands. Depends on gflt_pkg.
module gflt_front
    import gflt_pkg::*;
#(
    parameter int NUM_LOCKS = 15
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gflt_cmd_t in_cmd,
    output logic      cmd_valid,
    input  logic      cmd_ready,
    output gflt_cmd_t cmd
);

    // two-entry command queue
    gflt_cmd_t  q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       push;
    logic       pop;
    gflt_cmd_t  tagged_cmd;

    always_comb
    begin
        tagged_cmd = in_cmd;
        tagged_cmd.index_ok = (5'(in_cmd.lock_index) < 5'(NUM_LOCKS));
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[rd_reg ^ (cnt_reg[0] ^ (pop ? 1'b1 : 1'b0)) ^ (pop ? 1'b1 : 1'b0)]
                <= tagged_cmd;
        end
    end

endmodule

// ===== src/gflt_back.sv =====
// Back part: executes one command at a time against the lock state and
// the waiter RAMs, searching and closing up the queue one entry at a time.
// Depends on gflt_pkg and gflt_ram.
module gflt_back
    import gflt_pkg::*;
#(
    parameter int NUM_LOCKS   = 15,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  gflt_cmd_t cmd,
    output logic      res_valid,
    input  logic      res_ready,
    output gflt_res_t res
);

    localparam int LW   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int DEP  = NUM_LOCKS * QUEUE_DEPTH;
    localparam int AW   = (DEP > 1) ? $clog2(DEP) : 1;
    localparam int AXW  = AW + 8;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_SWAIT = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_SHW   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [NUM_LOCKS-1:0] active_reg;
    logic [6:0]           favor_reg [NUM_LOCKS];
    logic [ID_WIDTH-1:0]  holder_reg [NUM_LOCKS];
    logic [CW-1:0]        count_reg [NUM_LOCKS];

    logic [2:0]          state_reg;
    gflt_cmd_t           c_reg;
    gflt_res_t           res_reg;
    logic [CW-1:0]       i_reg;
    logic [CW-1:0]       win_reg;
    logic                found_reg;
    logic [ID_WIDTH-1:0] wpid_reg;

    logic [LW-1:0]       li;
    logic [ID_WIDTH-1:0] pid;
    logic [ID_WIDTH-1:0] gid;
    logic [CW-1:0]       n;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [ID_WIDTH-1:0] wr_pid;
    logic [ID_WIDTH-1:0] wr_gid;
    logic [ID_WIDTH-1:0] rd_pid;
    logic [ID_WIDTH-1:0] rd_gid;
    logic [CW-1:0]       rd_slot;

    assign li  = c_reg.lock_index[LW-1:0];
    assign pid = c_reg.caller_pid[ID_WIDTH-1:0];
    assign gid = c_reg.caller_gid[ID_WIDTH-1:0];
    assign n   = count_reg[li];

    function automatic logic [AW-1:0] addr_of(logic [LW-1:0] l, logic [CW-1:0] s);
        logic [AXW-1:0] a;
        a = AXW'(l) * AXW'(QUEUE_DEPTH) + AXW'(s);
        return a[AW-1:0];
    endfunction

    gflt_ram #(.WIDTH(ID_WIDTH), .DEPTH(DEP)) u_pid_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_pid),
        .rd_addr(rd_addr),
        .rd_data(rd_pid)
    );

    gflt_ram #(.WIDTH(ID_WIDTH), .DEPTH(DEP)) u_gid_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_gid),
        .rd_addr(rd_addr),
        .rd_data(rd_gid)
    );

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

    always_comb
    begin
        rd_slot = i_reg;
        if (state_reg == S_SHIFT)
        begin
            rd_slot = i_reg + CW'(1);
        end
        rd_addr = addr_of(li, rd_slot);
        wr_en   = 1'b0;
        wr_addr = addr_of(li, n);
        wr_pid  = pid;
        wr_gid  = gid;
        if (state_reg == S_SHW)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_of(li, i_reg);
            wr_pid  = rd_pid;
            wr_gid  = rd_gid;
        end
        else if (state_reg == S_SRCH && i_reg == CW'(0) && found_reg
                 && c_reg.action == ACT_ACQUIRE && res_reg.status == ST_QUEUED)
        begin
            // append the caller at the tail of the queue
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= '0;
            for (int k = 0; k < NUM_LOCKS; k++)
            begin
                favor_reg[k]  <= '0;
                holder_reg[k] <= '0;
                count_reg[k]  <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        c_reg     <= cmd;
                        res_reg   <= '{ST_ERROR, 4'd0, 1'b0, 16'd0};
                        i_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    // first cycle decodes; later cycles scan gids
                    if (i_reg == CW'(0) && !found_reg)
                    begin
                        state_reg <= S_OUT;
                        if (c_reg.action == ACT_CREATE)
                        begin
                            if (c_reg.favor_percent <= PCT_LIMIT)
                            begin
                                for (int k = NUM_LOCKS - 1; k >= 0; k--)
                                begin
                                    if (!active_reg[k])
                                    begin
                                        res_reg.status        <= ST_DONE;
                                        res_reg.created_index <= 4'(k);
                                    end
                                end
                            end
                        end
                        else if (c_reg.index_ok && active_reg[li])
                        begin
                            if (c_reg.action == ACT_ACQUIRE)
                            begin
                                if (pid != '0)
                                begin
                                    if (holder_reg[li] == '0)
                                    begin
                                        holder_reg[li] <= pid;
                                        res_reg.status <= ST_DONE;
                                    end
                                    else if (n < CW'(QUEUE_DEPTH))
                                    begin
                                        res_reg.status <= ST_QUEUED;
                                        found_reg      <= 1'b1;
                                        state_reg      <= S_SRCH;
                                    end
                                end
                            end
                            else if (c_reg.action == ACT_RELEASE)
                            begin
                                if (pid != '0 && holder_reg[li] == pid)
                                begin
                                    res_reg.status <= ST_DONE;
                                    if (n == '0)
                                    begin
                                        holder_reg[li] <= '0;
                                    end
                                    else
                                    begin
                                        win_reg   <= '0;
                                        found_reg <= 1'b1;
                                        state_reg <= S_SWAIT;
                                    end
                                end
                            end
                            else
                            begin
                                if (n == '0 && holder_reg[li] == '0)
                                begin
                                    res_reg.status <= ST_DONE;
                                end
                            end
                        end
                    end
                    else if (c_reg.action == ACT_ACQUIRE)
                    begin
                        // queue append is written in this cycle
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SWAIT;
                    end
                end
                S_SWAIT:
                begin
                    // rd data for slot i_reg valid now (read issued last cycle)
                    if (state_reg == S_SWAIT && i_reg == '0 && win_reg == '0
                        && !(c_reg.random_draw < favor_reg[li]))
                    begin
                        wpid_reg  <= rd_pid;
                        state_reg <= S_SHIFT;
                    end
                    else if (rd_gid == gid)
                    begin
                        win_reg   <= i_reg;
                        wpid_reg  <= rd_pid;
                        state_reg <= S_SHIFT;
                    end
                    else if (i_reg + CW'(1) >= n)
                    begin
                        i_reg     <= '0;
                        win_reg   <= '0;
                        state_reg <= S_SRCH;
                        found_reg <= 1'b0;
                        c_reg.random_draw <= 7'd127;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_SRCH;
                    end
                end
                S_SHIFT:
                begin
                    if (i_reg + CW'(1) >= n)
                    begin
                        holder_reg[li]     <= wpid_reg;
                        count_reg[li]      <= n - CW'(1);
                        res_reg.wake_valid <= 1'b1;
                        res_reg.wake_pid   <= 16'(wpid_reg);
                        state_reg          <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SHW;
                    end
                end
                S_SHW:
                begin
                    i_reg     <= i_reg + CW'(1);
                    state_reg <= S_SHIFT;
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            // append bumps count; successful create/destroy commit on result
            if (state_reg == S_SRCH && i_reg == CW'(0) && found_reg
                && c_reg.action == ACT_ACQUIRE)
            begin
                count_reg[li] <= n + CW'(1);
            end
            if (state_reg == S_OUT && res_ready && res_reg.status == ST_DONE)
            begin
                if (c_reg.action == ACT_CREATE)
                begin
                    active_reg[res_reg.created_index[LW-1:0]] <= 1'b1;
                    favor_reg[res_reg.created_index[LW-1:0]]  <= c_reg.favor_percent;
                    holder_reg[res_reg.created_index[LW-1:0]] <= '0;
                    count_reg[res_reg.created_index[LW-1:0]]  <= '0;
                end
                else if (c_reg.action == ACT_DESTROY)
                begin
                    active_reg[li] <= 1'b0;
                    favor_reg[li]  <= '0;
                end
            end
        end
    end

endmodule

// ===== src/group_favoring_lock_table.sv =====
// Top level of the group-favouring lock table.
// Depends on gflt_pkg, gflt_front and gflt_back.
//
// One result transaction per input transaction, in order. Create, destroy,
// a granted acquire and any error pass S_IDLE, S_SRCH (decode) and S_OUT;
// a queued acquire visits S_SRCH again to write the append. A release scans
// the waiter queue of the lock one entry at a time (S_SRCH reads, S_SWAIT
// checks the gid), then closes it up (S_SHIFT reads, S_SHW writes), paced
// by the waiter RAM port (one read, one write a cycle). A two-entry command
// queue lets new requests be taken while the executor is busy.
module group_favoring_lock_table
    import gflt_pkg::*;
#(
    parameter int NUM_LOCKS   = 15,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], lock_index[5:2], caller_pid[21:6], caller_gid[37:22],
    // favor_percent[44:38], random_draw[51:45], zero fill
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], created_index[5:2], wake_valid[6], wake_pid[22:7], zero fill
    output logic [23:0] m_axis_tdata
);

    gflt_cmd_t in_cmd;
    gflt_cmd_t cmd;
    gflt_res_t res;
    logic      cmd_valid;
    logic      cmd_ready;

    always_comb
    begin
        in_cmd.action        = s_axis_tdata[1:0];
        in_cmd.lock_index    = s_axis_tdata[5:2];
        in_cmd.caller_pid    = s_axis_tdata[21:6];
        in_cmd.caller_gid    = s_axis_tdata[37:22];
        in_cmd.favor_percent = s_axis_tdata[44:38];
        in_cmd.random_draw   = s_axis_tdata[51:45];
        in_cmd.index_ok      = 1'b0;
    end

    gflt_front #(.NUM_LOCKS(NUM_LOCKS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd)
    );

    gflt_back #(
        .NUM_LOCKS  (NUM_LOCKS),
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .res_valid(m_axis_tvalid),
        .res_ready(m_axis_tready),
        .res      (res)
    );

    assign m_axis_tdata = {1'b0, res.wake_pid, res.wake_valid, res.created_index, res.status};

endmodule

// ===== dv/group_favoring_lock_table_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the group-favouring lock table.
// Depends on gflt_pkg and group_favoring_lock_table; predicts every result in-line.

module group_favoring_lock_table_tb;
    import gflt_pkg::*;

    localparam int NLOCK  = 15;
    localparam int QDEPTH = 16;
    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    group_favoring_lock_table dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predicted lock table
    logic        pr_active [NLOCK];
    logic [6:0]  pr_favor  [NLOCK];
    logic [15:0] pr_holder [NLOCK];
    int          pr_count  [NLOCK];
    logic [15:0] pr_wpid   [NLOCK][QDEPTH];
    logic [15:0] pr_wgid   [NLOCK][QDEPTH];

    gflt_res_t pending_results[$];
    int        failures;
    int        idle_cycles;
    int        burst_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = 1'b1;
            #10 clk = 1'b0;
        end
    end

    function automatic gflt_res_t apply_request(logic [1:0] act, logic [3:0] idx,
                                                logic [15:0] pid, logic [15:0] gid,
                                                logic [6:0] fav, logic [6:0] draw);
        gflt_res_t r;
        int n;
        int win;
        r = '0;
        r.status = ST_ERROR;
        if (act == ACT_CREATE)
        begin
            if (fav <= PCT_LIMIT)
            begin
                for (int i = 0; i < NLOCK; i++)
                begin
                    if (!pr_active[i])
                    begin
                        pr_active[i] = 1'b1;
                        pr_favor[i]  = fav;
                        pr_holder[i] = '0;
                        pr_count[i]  = 0;
                        r.status = ST_DONE;
                        r.created_index = i[3:0];
                        break;
                    end
                end
            end
        end
        else if (idx < NLOCK && pr_active[idx])
        begin
            n = pr_count[idx];
            if (act == ACT_ACQUIRE)
            begin
                if (pid != 0)
                begin
                    if (pr_holder[idx] == 0)
                    begin
                        pr_holder[idx] = pid;
                        r.status = ST_DONE;
                    end
                    else if (n < QDEPTH)
                    begin
                        pr_wpid[idx][n] = pid;
                        pr_wgid[idx][n] = gid;
                        pr_count[idx] = n + 1;
                        r.status = ST_QUEUED;
                    end
                end
            end
            else if (act == ACT_RELEASE)
            begin
                if (pid != 0 && pr_holder[idx] == pid)
                begin
                    r.status = ST_DONE;
                    if (n == 0)
                        pr_holder[idx] = '0;
                    else
                    begin
                        win = 0;
                        if (draw < pr_favor[idx])
                        begin
                            for (int i = 0; i < n; i++)
                            begin
                                if (pr_wgid[idx][i] == gid)
                                begin
                                    win = i;
                                    break;
                                end
                            end
                        end
                        pr_holder[idx] = pr_wpid[idx][win];
                        r.wake_valid = 1'b1;
                        r.wake_pid = pr_wpid[idx][win];
                        for (int i = win; i + 1 < n; i++)
                        begin
                            pr_wpid[idx][i] = pr_wpid[idx][i + 1];
                            pr_wgid[idx][i] = pr_wgid[idx][i + 1];
                        end
                        pr_count[idx] = n - 1;
                    end
                end
            end
            else if (n == 0 && pr_holder[idx] == 0)
            begin
                pr_active[idx] = 1'b0;
                pr_favor[idx] = '0;
                r.status = ST_DONE;
            end
        end
        return r;
    endfunction

    // send one request, honouring the burst/gap pattern
    task automatic send_request(logic [1:0] act, logic [3:0] idx, logic [15:0] pid,
                                logic [15:0] gid, logic [6:0] fav, logic [6:0] draw);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, draw, fav, gid, pid, idx, act};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_results.push_back(apply_request(act, idx, pid, gid, fav, draw));
        burst_left--;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_request(ACT_ACQUIRE, 4'd0, 16'd1, 16'd0, 7'd0, 7'd0);   // inactive lock
        send_request(ACT_CREATE, 4'd0, 16'd0, 16'd0, 7'd101, 7'd0);  // bad percentage
        send_request(ACT_CREATE, 4'd0, 16'd0, 16'd0, 7'd127, 7'd0);
        send_request(ACT_CREATE, 4'd0, 16'd0, 16'd0, 7'd100, 7'd0);
        send_request(ACT_CREATE, 4'd0, 16'd0, 16'd0, 7'd0, 7'd0);
        send_request(ACT_ACQUIRE, 4'd15, 16'd5, 16'd0, 7'd0, 7'd0);  // bad index
        send_request(ACT_ACQUIRE, 4'd0, 16'd0, 16'd0, 7'd0, 7'd0);   // zero pid
        send_request(ACT_ACQUIRE, 4'd0, 16'hFFFF, 16'hFFFF, 7'd0, 7'd0);
        send_request(ACT_ACQUIRE, 4'd0, 16'hFFFF, 16'd1, 7'd0, 7'd0); // holder queues itself
        send_request(ACT_ACQUIRE, 4'd0, 16'd7, 16'd2, 7'd0, 7'd0);
        send_request(ACT_ACQUIRE, 4'd0, 16'd8, 16'hFFFF, 7'd0, 7'd0);
        send_request(ACT_RELEASE, 4'd0, 16'd9, 16'd0, 7'd0, 7'd0);   // non-holder
        send_request(ACT_DESTROY, 4'd0, 16'd0, 16'd0, 7'd0, 7'd0);   // busy
        send_request(ACT_RELEASE, 4'd0, 16'hFFFF, 16'hFFFF, 7'd0, 7'd99); // favoured gid
        send_request(ACT_RELEASE, 4'd0, 16'd8, 16'd2, 7'd0, 7'd127); // draw too high: head
        send_request(ACT_RELEASE, 4'hF, 16'hFFFF, 16'd0, 7'd0, 7'd0);
        send_request(ACT_RELEASE, 4'd0, 16'hFFFF, 16'd0, 7'd0, 7'd0);
        send_request(ACT_RELEASE, 4'd0, 16'd7, 16'd0, 7'd0, 7'd0);
        send_request(ACT_RELEASE, 4'd0, 16'd7, 16'd0, 7'd0, 7'd0);   // now free
        send_request(ACT_DESTROY, 4'd0, 16'd0, 16'd0, 7'd0, 7'd0);
        send_request(ACT_DESTROY, 4'd0, 16'd0, 16'd0, 7'd0, 7'd0);   // already inactive
        send_request(ACT_DESTROY, 4'd15, 16'd0, 16'd0, 7'd0, 7'd0);
    endtask

    // fill every slot, then overflow one queue
    task automatic test_full_table();
        for (int i = 0; i < NLOCK + 1; i++)
            send_request(ACT_CREATE, 4'd0, 16'd0, 16'd0, 7'($urandom_range(0, 100)), 7'd0);
        send_request(ACT_ACQUIRE, 4'd3, 16'd100, 16'd1, 7'd0, 7'd0);
        for (int i = 0; i < QDEPTH + 1; i++)
            send_request(ACT_ACQUIRE, 4'd3, 16'(200 + i), 16'($urandom_range(0, 3)),
                         7'd0, 7'd0);
        drain_results();
    endtask

    task automatic test_random(int total);
        logic [1:0]  act;
        logic [3:0]  idx;
        logic [15:0] pid;
        logic [15:0] gid;
        for (int k = 0; k < total; k++)
        begin
            idx = 4'($urandom_range(0, 4));
            act = 2'($urandom_range(0, 3));
            // mostly a small pool of pids and gids, so releases find holders and groups
            pid = 16'($urandom_range(1, 6));
            gid = 16'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
                act = ACT_ACQUIRE;
            if (act == ACT_RELEASE && pr_holder[idx] != 0 && $urandom_range(0, 4) != 0)
                pid = pr_holder[idx];
            if ($urandom_range(0, 19) == 0)
            begin
                idx = 4'($urandom);
                pid = 16'($urandom);
                gid = 16'($urandom);
            end
            if (act == ACT_CREATE && $urandom_range(0, 3) != 0)
                act = ACT_ACQUIRE;
            send_request(act, idx, pid, gid, 7'($urandom), 7'($urandom_range(0, 127)));
            if (k == total / 2)
                drain_results();
        end
    endtask

    initial
    begin
        failures = 0;
        burst_left = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        for (int i = 0; i < NLOCK; i++)
        begin
            pr_active[i] = 1'b0;
            pr_favor[i] = '0;
            pr_holder[i] = '0;
            pr_count[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random(2000);
        drain_results();
        repeat (100) @(posedge clk);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // receiver stalls on its own random pattern, independent of the sender
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) < 40)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        gflt_res_t want;
        gflt_res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status        = m_axis_tdata[1:0];
            got.created_index = m_axis_tdata[5:2];
            got.wake_valid    = m_axis_tdata[6];
            got.wake_pid      = m_axis_tdata[22:7];
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected: %h", m_axis_tdata);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    failures++;
                end
                if (got.created_index !== want.created_index)
                begin
                    $error("created_index: expected %0d, got %0d",
                           want.created_index, got.created_index);
                    failures++;
                end
                if (got.wake_valid !== want.wake_valid)
                begin
                    $error("wake_valid: expected %0d, got %0d",
                           want.wake_valid, got.wake_valid);
                    failures++;
                end
                if (got.wake_pid !== want.wake_pid)
                begin
                    $error("wake_pid: expected %0d, got %0d", want.wake_pid, got.wake_pid);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial idle_cycles = 0;

endmodule
